/* rtl/stop_and_wait_receiver_defines.svh */
// ----------------------------------------------------------------------------
// stop_and_wait_receiver assertion macros
// shared concurrent assertion forms for the receiver checker
// ----------------------------------------------------------------------------
`ifndef STOP_AND_WAIT_RECEIVER_DEFINES_SVH
`define STOP_AND_WAIT_RECEIVER_DEFINES_SVH

// checked only outside reset
`define SWR_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define SWR_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/swr_pkg.sv */
// ----------------------------------------------------------------------------
// swr_pkg
// shared types, constants and checksum helper of the stop-and-wait receiver
// ----------------------------------------------------------------------------
package swr_pkg;

   // parameter defaults
   localparam int PAYLOAD_MAX_DEF = 509;
   localparam int SEQ_BITS_DEF    = 8;

   // datagram layout
   localparam int POS_W    = 10;
   localparam int POS_CAP  = 1023;
   localparam logic [POS_W-1:0] POS_FLAG = 10'd1;
   localparam logic [POS_W-1:0] POS_SEQ  = 10'd2;
   localparam logic [POS_W-1:0] POS_LEN  = 10'd3;
   localparam logic [POS_W-1:0] POS_DATA = 10'd4;

   // counters
   localparam int PEND_W = 9;
   localparam logic [PEND_W-1:0] PEND_MAX = 9'd511;
   localparam int TOTAL_W = 32;

   // flag and checksum values
   localparam logic [7:0] FLAG_ACK  = 8'h01;
   localparam logic [7:0] FLAG_NAK  = 8'h02;
   localparam logic [7:0] FLAG_LAST = 8'h08;
   localparam logic [7:0] SUM_GOOD  = 8'hFF;

   // operation and result kind codes
   localparam logic OP_BYTE      = 1'b0;
   localparam logic OP_START     = 1'b1;
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // result queue
   localparam int FIFO_DEPTH = 8;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = PTR_W + 1;

   typedef struct packed {
      logic                 kind;
      logic [7:0]           data_byte;
      logic                 commit;
      logic                 reply_valid;
      logic                 reply_nak;
      logic [7:0]           reply_seq;
      logic [7:0]           reply_sum;
      logic                 transfer_done;
      logic [PEND_W-1:0]    payload_count;
      logic [TOTAL_W-1:0]   total_bytes;
      logic                 last;
   } rsp_type;

   // up to two results per transaction, first one in slot a
   typedef struct packed {
      logic    push_a;
      logic    push_b;
      rsp_type res_a;
      rsp_type res_b;
   } push_type;

   // 8-bit add with end-around carry
   function automatic logic [7:0] add_carry(input logic [7:0] s, input logic [7:0] b);
      logic [8:0] t;
      t = {1'b0, s} + {1'b0, b};
      return t[7:0] + {7'd0, t[8]};
   endfunction

endpackage

/* rtl/swr_core.sv */
// ----------------------------------------------------------------------------
// swr_core
// input register, per-datagram state and single-pass result generation
// ----------------------------------------------------------------------------
module swr_core #(
   parameter int PAYLOAD_MAX = swr_pkg::PAYLOAD_MAX_DEF,
   parameter int SEQ_BITS    = swr_pkg::SEQ_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic               op,
   input  logic [7:0]         rx_byte,
   input  logic               rx_end,
   output swr_pkg::push_type  push
);

   localparam int DGRAM_LIMIT = ((PAYLOAD_MAX + 4) > swr_pkg::POS_CAP) ?
                                swr_pkg::POS_CAP : (PAYLOAD_MAX + 4);
   localparam logic [swr_pkg::POS_W-1:0] POS_LIMIT = swr_pkg::POS_W'(DGRAM_LIMIT);
   localparam logic [swr_pkg::POS_W-1:0] POS_END   = swr_pkg::POS_W'(PAYLOAD_MAX + 3);

   // input register
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_op_ff;
   logic [7:0] s1_byte_ff;
   logic       s1_end_ff;

   // receiver state
   logic [SEQ_BITS-1:0]         exp_ff,   exp_in;
   logic [swr_pkg::POS_W-1:0]   pos_ff,   pos_in;
   logic [7:0]                  sum_ff,   sum_in;
   logic [7:0]                  flag_ff,  flag_in;
   logic [7:0]                  seq_ff,   seq_in;
   logic [7:0]                  len_ff,   len_in;
   logic [swr_pkg::PEND_W-1:0]  pend_ff,  pend_in;
   logic [swr_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic                        done_ff,  done_in;

   logic                        active;
   logic                        is_last;
   logic                        payload;
   logic                        nak;
   logic                        commit;
   logic [swr_pkg::PEND_W-1:0]  count;
   logic [swr_pkg::TOTAL_W:0]   total_sum;
   logic [7:0]                  reply_flag;
   swr_pkg::rsp_type            verdict;
   swr_pkg::rsp_type            data_res;

   assign s1_valid_in = accept;

   always_comb begin
      exp_in   = exp_ff;
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      flag_in  = flag_ff;
      seq_in   = seq_ff;
      len_in   = len_ff;
      pend_in  = pend_ff;
      total_in = total_ff;
      done_in  = done_ff;

      active     = !done_ff && (pos_ff < POS_LIMIT);
      is_last    = (flag_ff == swr_pkg::FLAG_LAST);
      payload    = 1'b0;
      nak        = 1'b0;
      commit     = 1'b0;
      count      = '0;
      total_sum  = '0;
      reply_flag = swr_pkg::FLAG_ACK;
      verdict    = '0;
      data_res   = '0;
      push       = '0;

      if (s1_valid_ff) begin
         if (s1_op_ff == swr_pkg::OP_START) begin
            exp_in   = '0;
            pos_in   = '0;
            sum_in   = '0;
            flag_in  = '0;
            seq_in   = '0;
            len_in   = '0;
            pend_in  = '0;
            total_in = '0;
            done_in  = 1'b0;
         end else begin
            if (active) begin
               sum_in = swr_pkg::add_carry(sum_ff, s1_byte_ff);
               pos_in = pos_ff + 1'b1;
               if (pos_ff == swr_pkg::POS_FLAG) begin
                  flag_in = s1_byte_ff;
               end else if (pos_ff == swr_pkg::POS_SEQ) begin
                  seq_in = s1_byte_ff;
               end else if (pos_ff == swr_pkg::POS_LEN && is_last) begin
                  len_in = s1_byte_ff;
               end else if (pos_ff >= swr_pkg::POS_LEN) begin
                  if (is_last) begin
                     payload = (pos_ff >= swr_pkg::POS_DATA) &&
                               ({1'b0, pos_ff} < ({1'b0, swr_pkg::POS_DATA} + 11'(len_ff)));
                  end else begin
                     payload = (pos_ff < POS_END);
                  end
               end
            end

            if (payload) begin
               if (pend_ff < swr_pkg::PEND_MAX) begin
                  pend_in = pend_ff + 1'b1;
               end
               data_res.kind      = swr_pkg::KIND_PAYLOAD;
               data_res.data_byte = s1_byte_ff;
               data_res.last      = !s1_end_ff;
            end

            // verdict works on the state as updated by this byte
            if (s1_end_ff) begin
               if (!done_ff) begin
                  nak = (sum_in != swr_pkg::SUM_GOOD);
                  commit = !nak && (seq_in == 8'(exp_ff));
               end
               if (commit) begin
                  count     = pend_in;
                  exp_in    = exp_ff + 1'b1;
                  total_sum = {1'b0, total_ff} + (swr_pkg::TOTAL_W + 1)'(pend_in);
                  total_in  = total_sum[swr_pkg::TOTAL_W] ? '1 :
                              total_sum[swr_pkg::TOTAL_W-1:0];
                  if (flag_in == swr_pkg::FLAG_LAST) begin
                     done_in = 1'b1;
                  end
               end
               reply_flag = nak ? swr_pkg::FLAG_NAK : swr_pkg::FLAG_ACK;

               verdict.kind          = swr_pkg::KIND_VERDICT;
               verdict.commit        = commit;
               verdict.reply_valid   = !done_ff;
               verdict.reply_nak     = nak;
               verdict.reply_seq     = done_ff ? 8'd0 : seq_in;
               verdict.reply_sum     = done_ff ? 8'd0 :
                                       ~swr_pkg::add_carry(reply_flag, seq_in);
               verdict.transfer_done = done_in;
               verdict.payload_count = count;
               verdict.total_bytes   = total_in;
               verdict.last          = 1'b1;

               pos_in  = '0;
               sum_in  = '0;
               flag_in = '0;
               seq_in  = '0;
               len_in  = '0;
               pend_in = '0;
            end

            if (payload) begin
               push.push_a = 1'b1;
               push.res_a  = data_res;
               push.push_b = s1_end_ff;
               push.res_b  = verdict;
            end else begin
               push.push_a = s1_end_ff;
               push.res_a  = verdict;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         exp_ff      <= '0;
         pos_ff      <= '0;
         sum_ff      <= '0;
         flag_ff     <= '0;
         seq_ff      <= '0;
         len_ff      <= '0;
         pend_ff     <= '0;
         total_ff    <= '0;
         done_ff     <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         exp_ff      <= exp_in;
         pos_ff      <= pos_in;
         sum_ff      <= sum_in;
         flag_ff     <= flag_in;
         seq_ff      <= seq_in;
         len_ff      <= len_in;
         pend_ff     <= pend_in;
         total_ff    <= total_in;
         done_ff     <= done_in;
      end
   end

   // transaction payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff   <= op;
         s1_byte_ff <= rx_byte;
         s1_end_ff  <= rx_end;
      end
   end

endmodule

/* rtl/swr_fifo.sv */
// ----------------------------------------------------------------------------
// swr_fifo
// result queue taking two results per cycle at most, giving one on out_ready
// ----------------------------------------------------------------------------
module swr_fifo (
   input  logic               clock,
   input  logic               reset,
   input  swr_pkg::push_type  push,
   output logic               in_ready,
   output logic               out_valid,
   input  logic               out_ready,
   output swr_pkg::rsp_type   out_data
);

   localparam logic [swr_pkg::CNT_W-1:0] ROOM_LIMIT =
      swr_pkg::CNT_W'(swr_pkg::FIFO_DEPTH - 4);

   swr_pkg::rsp_type mem_ff [swr_pkg::FIFO_DEPTH];

   logic [swr_pkg::PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [swr_pkg::PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [swr_pkg::CNT_W-1:0] count_ff,  count_in;
   logic [swr_pkg::PTR_W-1:0] wr_next;
   logic                      pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign wr_next   = wr_ptr_ff + 1'b1;

   // room for the transaction in the input register plus a new one
   assign in_ready = (count_ff <= ROOM_LIMIT);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + swr_pkg::PTR_W'(push.push_a) + swr_pkg::PTR_W'(push.push_b);
      rd_ptr_in = rd_ptr_ff + swr_pkg::PTR_W'(pop);
      count_in  = count_ff + swr_pkg::CNT_W'(push.push_a) + swr_pkg::CNT_W'(push.push_b)
                  - swr_pkg::CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push_a) begin
         mem_ff[wr_ptr_ff] <= push.res_a;
      end
      if (push.push_b) begin
         mem_ff[wr_next] <= push.res_b;
      end
   end

endmodule

/* rtl/stop_and_wait_receiver.sv */
// ----------------------------------------------------------------------------
// stop_and_wait_receiver
// stop-and-wait ARQ receiver with 8-bit end-around-carry checksum
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one transaction per received datagram byte (req_op = 0,
//   req_rx_end marks the datagram's final byte) or a start command
//   (req_op = 1) that clears sequence, totals and the done flag.
//   rsp channel: tentative payload bytes (rsp_kind = 0) as they arrive, and
//   one verdict (rsp_kind = 1) per datagram end with commit, ACK/NAK reply
//   fields, transfer_done and the byte counts. rsp_last marks the final
//   result of each request transaction.
//   Path: results of an accepted request pass the input register, then
//   the result queue, before they are presented.
//   Throughput: one request per cycle while req_ready is high; results leave
//   at one per cycle while rsp_ready is high, so a payload byte and a verdict
//   from one byte leave in turn. req_ready is set by the fill level of the
//   8-entry queue; it drops above four entries, which needs rsp_ready low.
//   Reset: synchronous, clears all receiver state and empties the queue.
// ----------------------------------------------------------------------------
module stop_and_wait_receiver #(
   parameter int PAYLOAD_MAX = swr_pkg::PAYLOAD_MAX_DEF,
   parameter int SEQ_BITS    = swr_pkg::SEQ_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_rx_end,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_commit,
   output logic        rsp_reply_valid,
   output logic        rsp_reply_nak,
   output logic [7:0]  rsp_reply_seq,
   output logic [7:0]  rsp_reply_sum,
   output logic        rsp_transfer_done,
   output logic [8:0]  rsp_payload_count,
   output logic [31:0] rsp_total_bytes,
   output logic        rsp_last
);

   logic              accept;
   swr_pkg::push_type push;
   swr_pkg::rsp_type  rsp;

   assign accept = req_valid && req_ready;

   swr_core #(
      .PAYLOAD_MAX (PAYLOAD_MAX),
      .SEQ_BITS    (SEQ_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .op      (req_op),
      .rx_byte (req_rx_byte),
      .rx_end  (req_rx_end),
      .push    (push)
   );

   swr_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp)
   );

   assign rsp_kind          = rsp.kind;
   assign rsp_data_byte     = rsp.data_byte;
   assign rsp_commit        = rsp.commit;
   assign rsp_reply_valid   = rsp.reply_valid;
   assign rsp_reply_nak     = rsp.reply_nak;
   assign rsp_reply_seq     = rsp.reply_seq;
   assign rsp_reply_sum     = rsp.reply_sum;
   assign rsp_transfer_done = rsp.transfer_done;
   assign rsp_payload_count = rsp.payload_count;
   assign rsp_total_bytes   = rsp.total_bytes;
   assign rsp_last          = rsp.last;

endmodule

/* rtl/swr_checker.sv */
// ----------------------------------------------------------------------------
// swr_checker
// port-level assertions for the stop-and-wait receiver, bound to the top
// ----------------------------------------------------------------------------
`include "stop_and_wait_receiver_defines.svh"

module swr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_kind,
   input logic [7:0]  rsp_data_byte,
   input logic        rsp_commit,
   input logic        rsp_reply_valid,
   input logic        rsp_reply_nak,
   input logic        rsp_last
);

   // stalled transaction holds
   `SWR_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_byte), "rsp changed while stalled")

   // a verdict is always the final result of its request
   `SWR_ASSERT(a_verdict_last, rsp_valid && rsp_kind |-> rsp_last, "verdict without last")

   // payload bytes carry no reply or commit
   `SWR_ASSERT(a_payload_clean, rsp_valid && !rsp_kind |-> !rsp_commit && !rsp_reply_valid, "payload byte with verdict fields")

   // committing needs an ACK reply
   `SWR_ASSERT(a_commit_ack, rsp_valid && rsp_commit |-> rsp_reply_valid && !rsp_reply_nak, "commit without ack")

   // result queue is empty right after reset
   `SWR_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "rsp valid after reset")

endmodule

bind stop_and_wait_receiver swr_checker u_swr_checker (.*);

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the stop-and-wait receiver: a directed table, then
// random datagrams, all checked result by result against a behavioral model
// ----------------------------------------------------------------------------
module tb;
   import swr_pkg::*;

   localparam int PMAX        = PAYLOAD_MAX_DEF;
   localparam int DGRAM_LIMIT = (PMAX + 4 > POS_CAP) ? POS_CAP : PMAX + 4;
   localparam logic [7:0] SEQ_MASK = 8'((1 << SEQ_BITS_DEF) - 1);
   localparam int ITEMS       = 850;
   localparam int QUIET_LIMIT = 2000;

   typedef struct {
      logic       op;
      logic [7:0] rx_byte;
      logic       rx_end;
      logic       typed;
      rsp_type    fixed;
   } stim_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_op = OP_BYTE;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        req_rx_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic        rsp_commit;
   logic        rsp_reply_valid;
   logic        rsp_reply_nak;
   logic [7:0]  rsp_reply_seq;
   logic [7:0]  rsp_reply_sum;
   logic        rsp_transfer_done;
   logic [8:0]  rsp_payload_count;
   logic [31:0] rsp_total_bytes;
   logic        rsp_last;

   stop_and_wait_receiver dut (.*);

   always #5 clock = ~clock;

   // receiver model state
   logic [7:0]  seq_due;
   logic [9:0]  dg_pos;
   logic [7:0]  dg_sum;
   logic [7:0]  dg_flag;
   logic [7:0]  dg_seq;
   logic [7:0]  dg_len;
   logic [8:0]  dg_count;
   logic [31:0] xfer_total;
   logic        xfer_done;

   rsp_type  arq_results[$];
   stim_type feed[$];
   int       faults = 0;
   int       taken = 0;
   int       quiet = 0;
   int       hold = 0;
   bit       calm = 1'b0;

   function automatic logic [7:0] fold_add(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] t;
      t = {1'b0, a} + {1'b0, b};
      if (t[8])
         t = {1'b0, t[7:0]} + 9'd1;
      return t[7:0];
   endfunction

   function automatic int pick_wait();
      return calm ? 0 : $urandom_range(0, 9);
   endfunction

   function automatic rsp_type mk_verdict(input logic commit, input logic rvalid,
                                          input logic nak, input logic [7:0] seq,
                                          input logic [7:0] sum, input logic done,
                                          input logic [8:0] count,
                                          input logic [31:0] total);
      rsp_type v;
      v = '0;
      v.kind          = KIND_VERDICT;
      v.commit        = commit;
      v.reply_valid   = rvalid;
      v.reply_nak     = nak;
      v.reply_seq     = seq;
      v.reply_sum     = sum;
      v.transfer_done = done;
      v.payload_count = count;
      v.total_bytes   = total;
      v.last          = 1'b1;
      return v;
   endfunction

   task automatic clear_dgram();
      dg_pos   = '0;
      dg_sum   = '0;
      dg_flag  = '0;
      dg_seq   = '0;
      dg_len   = '0;
      dg_count = '0;
   endtask

   // advances the model by one transaction and queues the results it causes
   task automatic arq_step(input logic op, input logic [7:0] b, input logic e);
      rsp_type r;
      logic    is_last;
      logic    pay;
      if (op == OP_START) begin
         clear_dgram();
         seq_due    = '0;
         xfer_total = '0;
         xfer_done  = 1'b0;
         return;
      end
      if (!xfer_done && int'(dg_pos) < DGRAM_LIMIT) begin
         is_last = (dg_flag == FLAG_LAST);
         pay     = 1'b0;
         dg_sum  = fold_add(dg_sum, b);
         if (dg_pos == POS_FLAG)
            dg_flag = b;
         else if (dg_pos == POS_SEQ)
            dg_seq = b;
         else if (dg_pos == POS_LEN && is_last)
            dg_len = b;
         else if (dg_pos >= POS_LEN) begin
            if (is_last)
               pay = (dg_pos >= POS_DATA) && (dg_pos < POS_DATA + {2'b00, dg_len});
            else
               pay = (int'(dg_pos) < PMAX + 3);
         end
         dg_pos = dg_pos + 10'd1;
         if (pay) begin
            r = '0;
            r.kind      = KIND_PAYLOAD;
            r.data_byte = b;
            r.last      = !e;
            arq_results.push_back(r);
            if (dg_count < PEND_MAX)
               dg_count = dg_count + 9'd1;
         end
      end
      if (e) begin
         r = '0;
         r.kind = KIND_VERDICT;
         r.last = 1'b1;
         if (!xfer_done) begin
            r.reply_valid = 1'b1;
            if (dg_sum != SUM_GOOD)
               r.reply_nak = 1'b1;
            else if (dg_seq == seq_due) begin
               r.commit        = 1'b1;
               r.payload_count = dg_count;
               seq_due         = (seq_due + 8'd1) & SEQ_MASK;
               if (xfer_total > 32'hFFFF_FFFF - {23'd0, dg_count})
                  xfer_total = 32'hFFFF_FFFF;
               else
                  xfer_total = xfer_total + {23'd0, dg_count};
               if (dg_flag == FLAG_LAST)
                  xfer_done = 1'b1;
            end
            r.reply_seq = dg_seq;
            r.reply_sum = ~fold_add(r.reply_nak ? FLAG_NAK : FLAG_ACK, dg_seq);
         end
         r.transfer_done = xfer_done;
         r.total_bytes   = xfer_total;
         arq_results.push_back(r);
         clear_dgram();
      end
   endtask

   task automatic put(input logic op, input logic [7:0] b, input logic e);
      stim_type s;
      s.op      = op;
      s.rx_byte = b;
      s.rx_end  = e;
      s.typed   = 1'b0;
      s.fixed   = '0;
      feed.push_back(s);
   endtask

   // a row whose verdict is written out by hand
   task automatic put_v(input logic [7:0] b, input rsp_type v);
      put(OP_BYTE, b, 1'b1);
      feed[feed.size() - 1].typed = 1'b1;
      feed[feed.size() - 1].fixed = v;
   endtask

   // one datagram, mostly well formed, with noise and start commands mixed in
   task automatic build_dgram();
      logic [7:0] body[$];
      logic [7:0] acc;
      logic       lastp;
      int         pick;
      int         n;
      int         cut;
      calm = ($urandom_range(0, 5) == 0);
      pick = $urandom_range(0, 99);
      if ((xfer_done && $urandom_range(0, 2) != 0) || pick < 3) begin
         put(OP_START, 8'($urandom), 1'($urandom));
         return;
      end
      if (pick < 13) begin
         n = $urandom_range(1, 8);
         for (int i = 0; i < n; i++)
            put(OP_BYTE, 8'($urandom), i == n - 1);
         return;
      end
      lastp = ($urandom_range(0, 9) == 0);
      n = ($urandom_range(0, 39) == 0) ? $urandom_range(500, 520) : $urandom_range(0, 12);
      if (lastp && n > 255)
         n = 255;
      body.push_back(8'h00);
      body.push_back(lastp ? FLAG_LAST :
                     (($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'h00));
      case ($urandom_range(0, 9))
         7: begin
            body.push_back(seq_due - 8'd1);
         end
         8, 9: begin
            body.push_back(8'($urandom));
         end
         default: begin
            body.push_back(seq_due);
         end
      endcase
      if (lastp)
         body.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'(n));
      for (int i = 0; i < n; i++)
         body.push_back(8'($urandom));
      // bytes past the position cap never enter the sum
      acc = 8'h00;
      for (int i = 1; i < body.size() && i < DGRAM_LIMIT; i++)
         acc = fold_add(acc, body[i]);
      body[0] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : ~acc;
      cut = body.size();
      if ($urandom_range(0, 9) == 0)
         cut = $urandom_range(1, body.size());
      for (int i = 0; i < cut; i++)
         put(OP_BYTE, body[i], i == cut - 1);
   endtask

   task automatic send(input stim_type s);
      int gap;
      gap = pick_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_op      <= s.op;
      req_rx_byte <= s.rx_byte;
      req_rx_end  <= s.rx_end;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      taken++;
      arq_step(s.op, s.rx_byte, s.rx_end);
      if (s.typed) begin
         void'(arq_results.pop_back());
         arq_results.push_back(s.fixed);
      end
   endtask

   task automatic drain_feed();
      while (feed.size() != 0)
         send(feed.pop_front());
   endtask

   task automatic report(input string msg);
      faults++;
      $display("mismatch at %0t: %s", $time, msg);
   endtask

   task automatic cmp_field(input string name, input logic [31:0] got,
                            input logic [31:0] want);
      if (got !== want)
         report($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   task automatic check_rsp();
      rsp_type want;
      if (arq_results.size() == 0) begin
         report($sformatf("result with nothing pending, kind %0b", rsp_kind));
         return;
      end
      want = arq_results.pop_front();
      cmp_field("kind", 32'(rsp_kind), 32'(want.kind));
      cmp_field("data_byte", 32'(rsp_data_byte), 32'(want.data_byte));
      cmp_field("commit", 32'(rsp_commit), 32'(want.commit));
      cmp_field("reply_valid", 32'(rsp_reply_valid), 32'(want.reply_valid));
      cmp_field("reply_nak", 32'(rsp_reply_nak), 32'(want.reply_nak));
      cmp_field("reply_seq", 32'(rsp_reply_seq), 32'(want.reply_seq));
      cmp_field("reply_sum", 32'(rsp_reply_sum), 32'(want.reply_sum));
      cmp_field("transfer_done", 32'(rsp_transfer_done), 32'(want.transfer_done));
      cmp_field("payload_count", 32'(rsp_payload_count), 32'(want.payload_count));
      cmp_field("total_bytes", rsp_total_bytes, want.total_bytes);
      cmp_field("last", 32'(rsp_last), 32'(want.last));
   endtask

   // result side: random stall after each transaction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_rsp();
            hold = pick_wait();
         end else if (hold > 0)
            hold--;
         rsp_ready <= (hold == 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet <= 0;
      else if (quiet >= QUIET_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else
         quiet <= quiet + 1;
   end

   initial begin
      clear_dgram();
      seq_due    = '0;
      xfer_total = '0;
      xfer_done  = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // good datagram, no payload, expected sequence
      put(OP_BYTE, 8'hFF, 1'b0);
      put(OP_BYTE, 8'h00, 1'b0);
      put_v(8'h00, mk_verdict(1'b1, 1'b1, 1'b0, 8'h00, 8'hFE, 1'b0, 9'd0, 32'd0));
      // bad checksum
      put(OP_BYTE, 8'h00, 1'b0);
      put(OP_BYTE, 8'h00, 1'b0);
      put_v(8'h05, mk_verdict(1'b0, 1'b1, 1'b1, 8'h05, 8'hF8, 1'b0, 9'd0, 32'd0));
      // good checksum, unexpected sequence
      put(OP_BYTE, 8'hF8, 1'b0);
      put(OP_BYTE, 8'h00, 1'b0);
      put_v(8'h07, mk_verdict(1'b0, 1'b1, 1'b0, 8'h07, 8'hF7, 1'b0, 9'd0, 32'd0));
      // payload extremes, final byte is payload too
      put(OP_BYTE, 8'h7E, 1'b0);
      put(OP_BYTE, 8'h00, 1'b0);
      put(OP_BYTE, 8'h01, 1'b0);
      put(OP_BYTE, 8'hFF, 1'b0);
      put(OP_BYTE, 8'h00, 1'b0);
      put(OP_BYTE, 8'h80, 1'b1);
      // last packet, length 2, one trailing byte past the length
      put(OP_BYTE, 8'h1E, 1'b0);
      put(OP_BYTE, FLAG_LAST, 1'b0);
      put(OP_BYTE, 8'h02, 1'b0);
      put(OP_BYTE, 8'h02, 1'b0);
      put(OP_BYTE, 8'h01, 1'b0);
      put(OP_BYTE, 8'h7F, 1'b0);
      put(OP_BYTE, 8'h55, 1'b1);
      // transfer done: silent verdict
      put_v(8'h00, mk_verdict(1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b1, 9'd0, 32'd5));
      put(OP_START, 8'hFF, 1'b1);
      drain_feed();

      while (taken < ITEMS) begin
         build_dgram();
         drain_feed();
      end
      req_valid <= 1'b0;

      while (arq_results.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
      if (faults == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
